FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on the rising edge of clk.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/aeskg_pkg.sv
// ---------------------------------------------------------------------------
// AES-128 key expansion package
// Constants, tables and the pipeline word type shared by the key generator.
// ---------------------------------------------------------------------------
package aeskg_pkg;

  localparam int unsigned ROUNDS_DEF = 10;
  localparam int unsigned KEY_W      = 128;
  localparam int unsigned HALF_W     = 64;
  localparam int unsigned IDX_W      = 4;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } item_t;

  localparam logic [7:0] RCON [ROUNDS_DEF] = '{
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
  };

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

endpackage

FILE: src/aeskg_intf.sv
// ---------------------------------------------------------------------------
// AES-128 key expansion channels
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface aeskg_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] key_hi;
  logic [63:0] key_lo;
  logic [3:0]  round_index;

  modport source (output valid, key_hi, key_lo, round_index, input ready);
  modport sink (input valid, key_hi, key_lo, round_index, output ready);
endinterface

interface aeskg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] round_key_hi;
  logic [63:0] round_key_lo;

  modport source (output valid, round_key_hi, round_key_lo, input ready);
  modport sink (input valid, round_key_hi, round_key_lo, output ready);
endinterface

FILE: src/aeskg_round_stage.sv
// ---------------------------------------------------------------------------
// AES-128 key expansion round stage
// One expansion round followed by a pipeline register with its own valid bit.
// The round is applied only when the word's round index reaches this stage.
// ---------------------------------------------------------------------------
module aeskg_round_stage
  import aeskg_pkg::*;
#(
  parameter int unsigned RND = 0
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  item_t up_item,
  output logic  dn_valid,
  input  logic  dn_ready,
  output item_t dn_item
);

  localparam logic [IDX_W-1:0] RND_IDX = IDX_W'(RND);

  logic        valid_r;
  logic        valid_nxt;
  item_t       item_r;
  item_t       item_nxt;
  logic [31:0] w0, w1, w2, w3;
  logic [31:0] rot;
  logic [31:0] t;
  logic [31:0] n0, n1, n2, n3;

  always_comb begin
    w0  = up_item.key[127:96];
    w1  = up_item.key[95:64];
    w2  = up_item.key[63:32];
    w3  = up_item.key[31:0];
    rot = {w3[23:0], w3[31:24]};
    t   = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]}
          ^ {RCON[RND], 24'h000000};
    n0  = w0 ^ t;
    n1  = w1 ^ n0;
    n2  = w2 ^ n1;
    n3  = w3 ^ n2;
    item_nxt.idx = up_item.idx;
    if (RND_IDX <= up_item.idx) begin
      item_nxt.key = {n0, n1, n2, n3};
    end else begin
      item_nxt.key = up_item.key;
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

FILE: src/aes128_round_key_generator_core.sv
// ---------------------------------------------------------------------------
// AES-128 round key generator
// Expands a cipher key to the round key for a requested round, one expansion
// round per pipeline stage.
// ---------------------------------------------------------------------------
// Channel  Dir  Payload                               Handshake
// in_ch    in   key_hi, key_lo, round_index           valid/ready
// out_ch   out  round_key_hi, round_key_lo            valid/ready
//
// The path is an input register followed by one register stage per expansion
// round, each stage holding four S-box lookups and an XOR chain.
// A new word may enter on every cycle when the result side keeps up.
// Reset clears only the valid bits; the block keeps no state between words.
// A stall on the result side fills empty stages first and loses nothing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module aes128_round_key_generator_core
  import aeskg_pkg::*;
#(
  parameter int unsigned ROUNDS = ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  aeskg_in_if.sink    in_ch,
  aeskg_out_if.source out_ch
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUNDS - 1);

  logic  in_valid_r;
  logic  in_valid_nxt;
  item_t in_item_r;
  item_t in_item_nxt;
  logic  in_ready;

  logic  stg_valid [ROUNDS+1];
  logic  stg_ready [ROUNDS+1];
  item_t stg_item  [ROUNDS+1];

  always_comb begin
    in_item_nxt.key = {in_ch.key_hi, in_ch.key_lo};
    if (in_ch.round_index > LAST_IDX) begin
      in_item_nxt.idx = LAST_IDX;
    end else begin
      in_item_nxt.idx = in_ch.round_index;
    end
  end

  assign in_ready     = !in_valid_r || stg_ready[0];
  assign in_valid_nxt = in_ready ? in_ch.valid : in_valid_r;
  assign in_ch.ready  = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      in_item_r <= in_item_nxt;
    end
  end

  assign stg_valid[0] = in_valid_r;
  assign stg_item[0]  = in_item_r;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    aeskg_round_stage #(
      .RND (r)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[r]),
      .up_ready (stg_ready[r]),
      .up_item  (stg_item[r]),
      .dn_valid (stg_valid[r+1]),
      .dn_ready (stg_ready[r+1]),
      .dn_item  (stg_item[r+1])
    );
  end

  assign stg_ready[ROUNDS]   = out_ch.ready;
  assign out_ch.valid        = stg_valid[ROUNDS];
  assign out_ch.round_key_hi = stg_item[ROUNDS].key[KEY_W-1:HALF_W];
  assign out_ch.round_key_lo = stg_item[ROUNDS].key[HALF_W-1:0];

  `ASSERT_IMPL(a_idx_saturated, in_valid_r, in_item_r.idx <= LAST_IDX,
    "Round index in the pipeline exceeds the last round.")
  `ASSERT_IMPL(a_ready_when_drained, !out_ch.valid, in_ch.ready,
    "Input not ready although the result stage is empty.")
  `ASSERT_NEXT(a_input_captured, in_ch.valid && in_ch.ready, in_valid_r,
    "Accepted word missing from the input register.")

endmodule
